[src/bpc_pkg.sv]
// package: shared types, constants and helpers for the pressure compensation core
`default_nettype none

package bpc_pkg;

    localparam int DIV_STEPS = 32;

    localparam logic [2:0] REG_CAL_A = 3'd0;
    localparam logic [2:0] REG_CAL_B = 3'd1;
    localparam logic [2:0] REG_CAL_C = 3'd2;
    localparam logic [2:0] REG_OSS   = 3'd3;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] K_SQ       = 32'd3038;
    localparam logic [31:0] K_LIN      = 32'd7357;
    localparam logic [31:0] K_OFS      = 32'd3791;
    localparam logic [31:0] K_SCALE    = 32'd50000;
    localparam logic [31:0] K_HALF     = 32'd32768;

    // every field that some stage produces; unused ones are trimmed by synthesis
    typedef struct packed {
        logic [31:0] up;
        logic [31:0] prod;
        logic [31:0] x1;
        logic [31:0] dvd;
        logic [31:0] dvs;
        logic        neg;
        logic        err;
        logic [31:0] temp;
        logic [31:0] b6;
        logic [31:0] m_b6b6;
        logic [31:0] m_ac2;
        logic [31:0] m_ac3;
        logic [31:0] sq;
        logic [31:0] x2a;
        logic [31:0] x1b;
        logic [31:0] m_b2;
        logic [31:0] m_b1;
        logic [31:0] b3;
        logic [31:0] x3p;
        logic [31:0] m_b4;
        logic [31:0] diff;
        logic [31:0] b7;
        logic        shl;
        logic [31:0] p;
        logic [31:0] m_sq;
        logic [31:0] m_lin;
        logic [31:0] m3;
        logic [31:0] x2;
        logic [31:0] temp_o;
        logic [31:0] p_o;
    } pipe_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] sh);
        return 32'($signed(v) >>> sh);
    endfunction

endpackage

`default_nettype wire

[src/bpc_if.sv]
// stream interfaces for raw samples and compensated results
`default_nettype none

interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temp;
    logic [23:0] raw_pressure;

    modport source (output valid, output raw_temp, output raw_pressure, input ready);
    modport sink (input valid, input raw_temp, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_error, input ready);
    modport sink (input valid, input temperature_tenths, input pressure_pa,
                  input divide_error, output ready);
endinterface

`default_nettype wire

[src/bpc_div.sv]
// pipelined unsigned 32/32 restoring divider, one quotient bit per stage
`default_nettype none

module bpc_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [31:0]   dividend,
    input  wire logic [31:0]   divisor,
    input  wire bpc_pkg::pipe_t in_side,
    output logic               out_valid,
    output logic [31:0]        quotient,
    output bpc_pkg::pipe_t     out_side
);
    import bpc_pkg::*;

    logic [DIV_STEPS-1:0] v_reg;
    logic [31:0]          rem_reg  [DIV_STEPS];
    logic [31:0]          num_reg  [DIV_STEPS];
    logic [31:0]          quo_reg  [DIV_STEPS];
    logic [31:0]          den_reg  [DIV_STEPS];
    pipe_t                side_reg [DIV_STEPS];
    logic [31:0]          rem_next [DIV_STEPS];
    logic [31:0]          num_next [DIV_STEPS];
    logic [31:0]          quo_next [DIV_STEPS];
    logic [31:0]          den_next [DIV_STEPS];
    pipe_t                side_next[DIV_STEPS];

    always_comb
    begin
        logic [31:0] r_prev;
        logic [31:0] n_prev;
        logic [31:0] q_prev;
        logic [31:0] d_prev;
        logic [32:0] t;
        logic [32:0] sub;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                r_prev       = '0;
                n_prev       = dividend;
                q_prev       = '0;
                d_prev       = divisor;
                side_next[k] = in_side;
            end
            else
            begin
                r_prev       = rem_reg[k-1];
                n_prev       = num_reg[k-1];
                q_prev       = quo_reg[k-1];
                d_prev       = den_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            t   = {r_prev, n_prev[31]};
            sub = t - {1'b0, d_prev};
            ge  = (t >= {1'b0, d_prev});
            rem_next[k] = ge ? sub[31:0] : t[31:0];
            num_next[k] = {n_prev[30:0], 1'b0};
            quo_next[k] = {q_prev[30:0], ge};
            den_next[k] = d_prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= num_next[k];
                quo_reg[k]  <= quo_next[k];
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign quotient  = quo_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_valid |=> v_reg[0])
        else $error("divider dropped an entering transaction");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("divider valid bits moved during stall");
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> v_reg[DIV_STEPS-1:1] == $past(v_reg[DIV_STEPS-2:0]))
        else $error("divider valid bits did not advance");

endmodule

`default_nettype wire

[src/barometric_pressure_compensation_core.sv]
// top level: calibration registers, compensation pipeline and result register
`default_nettype none

// Turns a raw temperature word and raw pressure reading into temperature in
// 0.1 degC and pressure in Pa using the standard integer compensation formula.
// One transaction is accepted every cycle unless the output stalls; a result
// passes 14 arithmetic stages and two 32-stage dividers (one quotient bit per
// stage). The whole pipeline freezes while a result waits on the output, so
// no sample is lost. When either divisor is zero, divide_error is set and both
// results are zero. Calibration and oversampling must be written through
// the cfg port while no transaction is in flight; the block does not enforce it.
module barometric_pressure_compensation_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    bpc_in_if.sink          sample,
    bpc_out_if.source       result
);
    import bpc_pkg::*;

    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    logic        en;
    logic [14:1] v_reg;
    logic [14:1] v_next;
    pipe_t       s_reg  [1:14];
    pipe_t       s_next [1:14];

    logic        d1_valid, d2_valid;
    logic [31:0] d1_q, d2_q;
    pipe_t       d1_side, d2_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_CAL_C: cal_c_reg <= cfg_data[31:0];
                REG_OSS:   oss_reg   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    assign ac1 = sx16(cal_a_reg[63:48]);
    assign ac2 = sx16(cal_a_reg[47:32]);
    assign ac3 = sx16(cal_a_reg[31:16]);
    assign ac4 = {16'b0, cal_a_reg[15:0]};
    assign ac5 = {16'b0, cal_b_reg[63:48]};
    assign ac6 = {16'b0, cal_b_reg[47:32]};
    assign b1  = sx16(cal_b_reg[31:16]);
    assign b2  = sx16(cal_b_reg[15:0]);
    assign mc  = sx16(cal_c_reg[31:16]);
    assign md  = sx16(cal_c_reg[15:0]);

    assign en           = !v_reg[14] || result.ready;
    assign sample.ready = en;

    always_comb
    begin
        logic [31:0] na;
        logic [31:0] qs;
        logic [31:0] b5;
        logic [31:0] x3;
        logic [31:0] a8;
        logic [31:0] b4v;

        v_next[1] = sample.valid;
        for (int k = 2; k <= 14; k++)
            v_next[k] = v_reg[k-1];
        v_next[3]  = d1_valid;
        v_next[11] = d2_valid;

        // raw pressure alignment and the first temperature product
        s_next[1]      = '0;
        s_next[1].up   = {8'b0, sample.raw_pressure} >> (4'd8 - {2'b00, oss_reg});
        s_next[1].prod = ({16'b0, sample.raw_temp} - ac6) * ac5;

        // temperature divisor; divide on magnitudes, fix sign afterwards
        s_next[2]     = s_reg[1];
        s_next[2].x1  = asr(s_reg[1].prod, 5'd15);
        s_next[2].dvs = s_next[2].x1 + md;
        s_next[2].err = (s_next[2].dvs == '0);
        na            = mc << 11;
        s_next[2].neg = na[31] ^ s_next[2].dvs[31];
        s_next[2].dvd = na[31] ? -na : na;
        if (s_next[2].dvs[31])
            s_next[2].dvs = -s_next[2].dvs;

        s_next[3]      = d1_side;
        qs             = d1_side.neg ? -d1_q : d1_q;
        b5             = d1_side.x1 + qs;
        s_next[3].temp = asr(b5 + 32'd8, 5'd4);
        s_next[3].b6   = b5 - B6_OFFSET;

        s_next[4]        = s_reg[3];
        s_next[4].m_b6b6 = s_reg[3].b6 * s_reg[3].b6;
        s_next[4].m_ac2  = ac2 * s_reg[3].b6;
        s_next[4].m_ac3  = ac3 * s_reg[3].b6;

        s_next[5]     = s_reg[4];
        s_next[5].sq  = asr(s_reg[4].m_b6b6, 5'd12);
        s_next[5].x2a = asr(s_reg[4].m_ac2, 5'd11);
        s_next[5].x1b = asr(s_reg[4].m_ac3, 5'd13);

        s_next[6]      = s_reg[5];
        s_next[6].m_b2 = b2 * s_reg[5].sq;
        s_next[6].m_b1 = b1 * s_reg[5].sq;

        s_next[7]     = s_reg[6];
        x3            = asr(s_reg[6].m_b2, 5'd11) + s_reg[6].x2a;
        s_next[7].b3  = asr((((ac1 << 2) + x3) << oss_reg) + 32'd2, 5'd2);
        s_next[7].x3p = asr(s_reg[6].x1b + asr(s_reg[6].m_b1, 5'd16) + 32'd2, 5'd2);

        s_next[8]      = s_reg[7];
        s_next[8].m_b4 = ac4 * (s_reg[7].x3p + K_HALF);
        s_next[8].diff = s_reg[7].up - s_reg[7].b3;

        s_next[9]     = s_reg[8];
        s_next[9].b7  = s_reg[8].diff * (K_SCALE >> oss_reg);

        // pressure divisor; shift the dividend left only when it stays in range
        s_next[10]     = s_reg[9];
        b4v            = s_reg[9].m_b4 >> 15;
        s_next[10].dvs = b4v;
        s_next[10].err = s_reg[9].err || (b4v == '0);
        s_next[10].shl = s_reg[9].b7[31];
        s_next[10].dvd = s_reg[9].b7[31] ? s_reg[9].b7 : (s_reg[9].b7 << 1);

        s_next[11]   = d2_side;
        s_next[11].p = d2_side.shl ? (d2_q << 1) : d2_q;

        s_next[12]       = s_reg[11];
        a8               = asr(s_reg[11].p, 5'd8);
        s_next[12].m_sq  = a8 * a8;
        s_next[12].m_lin = K_LIN * s_reg[11].p;

        s_next[13]    = s_reg[12];
        s_next[13].m3 = s_reg[12].m_sq * K_SQ;
        s_next[13].x2 = asr(32'd0 - s_reg[12].m_lin, 5'd16);

        s_next[14] = s_reg[13];
        if (s_reg[13].err)
        begin
            s_next[14].temp_o = '0;
            s_next[14].p_o    = '0;
        end
        else
        begin
            s_next[14].temp_o = s_reg[13].temp;
            s_next[14].p_o    = s_reg[13].p
                + asr(asr(s_reg[13].m3, 5'd16) + s_reg[13].x2 + K_OFS, 5'd4);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= 14; k++)
                s_reg[k] <= s_next[k];
        end
    end

    bpc_div u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[2]),
        .dividend  (s_reg[2].dvd),
        .divisor   (s_reg[2].dvs),
        .in_side   (s_reg[2]),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .out_side  (d1_side)
    );

    bpc_div u_div_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[10]),
        .dividend  (s_reg[10].dvd),
        .divisor   (s_reg[10].dvs),
        .in_side   (s_reg[10]),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .out_side  (d2_side)
    );

    assign result.valid              = v_reg[14];
    assign result.temperature_tenths = $signed(s_reg[14].temp_o);
    assign result.pressure_pa        = $signed(s_reg[14].p_o);
    assign result.divide_error       = s_reg[14].err;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.divide_error |->
            result.temperature_tenths == 0 && result.pressure_pa == 0)
        else $error("error result carries nonzero fields");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready == (!result.valid || result.ready))
        else $error("input ready disagrees with output stall");
    a_oss_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_OSS |=> oss_reg == $past(cfg_data[1:0]))
        else $error("oversampling write lost");

endmodule

`default_nettype wire
